// ===== src/tpss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpss_pkg: shared types and constants of the tour pair swap search core
// widths of the fixed fields, item modes, register map, reset values
// ----------------------------------------------------------------------------
package tpss_pkg;

	localparam int MAX_CITIES_DEF = 64;
	localparam int COORD_BITS_DEF = 12;

	localparam int SLOT_W  = 6;
	localparam int CID_W   = 6;
	localparam int IN_CRD_W = 12;
	localparam int LEN_W   = 20;
	localparam int CNT_W   = 13;
	localparam int CCNT_W  = 7;

	localparam logic [LEN_W-1:0]  LEN_MAX        = 20'hFFFFF;
	localparam logic [CCNT_W-1:0] CITY_COUNT_RST = 7'd50;

	// register map (index into the register list)
	localparam logic REG_CITY_COUNT = 1'b0;

	typedef enum logic [1:0] {
		MODE_CITY = 2'd0,
		MODE_TOUR = 2'd1,
		MODE_SWAP = 2'd2,
		MODE_NONE = 2'd3
	} tpss_mode_t;

	// write enables of the store
	typedef struct packed {
		logic tour;
		logic city;
	} tpss_wen_t;

endpackage

// ===== src/tour_pair_swap_search_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tour_pair_swap_search_core: two-city swap local search over a closed tour
// keeps coordinates, tour and used-pair table; judges one swap per item
// ----------------------------------------------------------------------------
// After reset the core clears its used-pair table, one entry per cycle, all
// MAX_CITIES*MAX_CITIES entries (4096 at the default), with busy high; register
// writes are taken during that time. Load items (city coordinates, tour slot)
// and unused mode codes are answered while busy stays low; the result strobe
// done pulses in the next cycle. A swap trial walks the tour edge by edge,
// once before and, when the swap is tried, once after it; each edge goes
// through two memory reads, difference, squares, sum and the square root
// unit, which gives one root bit per cycle. When a trial ends, done pulses in
// the same cycle as busy falls. The result is marked by done for exactly one
// cycle, and must be taken then: there is no way to hold it off. Lengths
// saturate at 1048575 on the ports; the keep/revert decision uses the exact sum.
// ----------------------------------------------------------------------------
module tour_pair_swap_search_core #(
	parameter int MAX_CITIES = tpss_pkg::MAX_CITIES_DEF,
	parameter int COORD_BITS = tpss_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// item command port
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        mode,
	input  logic [tpss_pkg::SLOT_W-1:0]       slot,
	input  logic [tpss_pkg::SLOT_W-1:0]       second_slot,
	input  logic [tpss_pkg::CID_W-1:0]        city_id,
	input  logic [tpss_pkg::IN_CRD_W-1:0]     coord_x,
	input  logic [tpss_pkg::IN_CRD_W-1:0]     coord_y,
	// result port
	output logic                              done,
	output logic                              accepted,
	output logic                              swapped,
	output logic [tpss_pkg::LEN_W-1:0]        old_length,
	output logic [tpss_pkg::LEN_W-1:0]        new_length,
	output logic [tpss_pkg::CNT_W-1:0]        pairs_used,
	output logic                              exhausted,
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int IDX_W      = $clog2(MAX_CITIES);
	localparam int RW         = COORD_BITS + 1;
	localparam int SQ1_W      = 2 * COORD_BITS;
	localparam int SQ_W       = 2 * RW;
	localparam int ACC_RAW    = RW + $clog2(MAX_CITIES) + 1;
	localparam int ACC_W      = (ACC_RAW > tpss_pkg::LEN_W) ? ACC_RAW : tpss_pkg::LEN_W + 1;
	localparam int PAIR_DEPTH = MAX_CITIES * MAX_CITIES;
	localparam int PAIR_W     = $clog2(PAIR_DEPTH);
	localparam int CCNT_W     = tpss_pkg::CCNT_W;
	localparam int CNT_W      = tpss_pkg::CNT_W;
	localparam int LEN_W      = tpss_pkg::LEN_W;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_TRD, S_CRD, S_DIFF, S_MUL, S_ADD, S_SQ, S_LEND,
		S_PRD, S_PDEC, S_SW1, S_SW2, S_RV1, S_RV2, S_FIN
	} state_t;

	state_t state_q;

	// registers
	logic [CCNT_W-1:0]         city_count_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [PAIR_W-1:0]         clr_q;
	logic [tpss_pkg::SLOT_W-1:0] slot_q;
	logic [tpss_pkg::SLOT_W-1:0] sec_q;
	logic                      inr_q;
	logic                      phase_q;
	logic [IDX_W-1:0]          i_q;
	logic [ACC_W-1:0]          acc_q;
	logic [ACC_W-1:0]          before_q;
	logic [ACC_W-1:0]          after_q;
	logic [tpss_pkg::CID_W-1:0] t1_q;
	logic [tpss_pkg::CID_W-1:0] t2_q;
	logic                      va_q;
	logic                      vb_q;
	logic [COORD_BITS-1:0]     dx_q;
	logic [COORD_BITS-1:0]     dy_q;
	logic [SQ1_W-1:0]          sqx_q;
	logic [SQ1_W-1:0]          sqy_q;
	logic                      done_q;
	logic                      acc_out_q;
	logic                      swp_out_q;
	logic [LEN_W-1:0]          old_q;
	logic [LEN_W-1:0]          new_q;
	logic [CNT_W-1:0]          used_q;
	logic                      exh_q;

	// pair table
	logic                      pair_mem [PAIR_DEPTH];
	logic                      pair_rd_q;
	logic                      pair_we;
	logic [PAIR_W-1:0]         pair_wa;
	logic                      pair_wd;
	logic [PAIR_W-1:0]         pair_idx;

	// combinational
	tpss_pkg::tpss_mode_t      in_mode;
	logic                      take;
	logic                      slot_ok;
	logic [CCNT_W-1:0]         n;
	logic [IDX_W-1:0]          last_idx;
	logic [IDX_W-1:0]          nxt_idx;
	logic                      in_range;
	logic                      exh_now;
	logic [2*CCNT_W-1:0]       target;
	logic [LEN_W-1:0]          sat_before;
	logic [LEN_W-1:0]          sat_after;
	logic [COORD_BITS-1:0]     xa_v, ya_v, xb_v, yb_v;
	logic                      edge_round;
	logic [ACC_W-1:0]          edge_len;

	// store and root unit
	tpss_pkg::tpss_wen_t       wen;
	logic [IDX_W-1:0]          waddr;
	logic [tpss_pkg::CID_W-1:0] tour_wdata;
	logic [IDX_W-1:0]          tour_ra, tour_rb;
	logic [tpss_pkg::CID_W-1:0] tour_qa, tour_qb;
	logic [IDX_W-1:0]          city_ra, city_rb;
	logic [COORD_BITS-1:0]     xa, ya, xb, yb;
	logic                      sq_start;
	logic [SQ_W-1:0]           sq_din;
	logic                      sq_done;
	logic [RW-1:0]             sq_root;
	logic [RW:0]               sq_rem;

	// active city count, capped at the table size
	always_comb begin
		n = (32'(city_count_q) > MAX_CITIES) ? CCNT_W'(MAX_CITIES) : city_count_q;
		last_idx = IDX_W'(n - 1'b1);
		nxt_idx  = (i_q == last_idx) ? '0 : i_q + 1'b1;
		target   = (2*CCNT_W)'(n) * (2*CCNT_W)'(n) - 1'b1;
		exh_now  = (n != '0) && ((2*CCNT_W)'(cnt_q) == target);
	end

	always_comb begin
		in_mode  = tpss_pkg::tpss_mode_t'(mode);
		take     = start && !busy;
		slot_ok  = 32'(slot) < MAX_CITIES;
		in_range = ({1'b0, slot} < n) && ({1'b0, second_slot} < n);
		pair_idx = PAIR_W'(32'(slot_q) * MAX_CITIES + 32'(sec_q));
	end

	always_comb begin
		sat_before = (before_q > ACC_W'(tpss_pkg::LEN_MAX)) ? tpss_pkg::LEN_MAX
		                                                    : before_q[LEN_W-1:0];
		sat_after  = (after_q > ACC_W'(tpss_pkg::LEN_MAX)) ? tpss_pkg::LEN_MAX
		                                                   : after_q[LEN_W-1:0];
	end

	// cities beyond the table read as the origin
	always_comb begin
		xa_v = va_q ? xa : '0;
		ya_v = va_q ? ya : '0;
		xb_v = vb_q ? xb : '0;
		yb_v = vb_q ? yb : '0;
	end

	// closing edge is truncated, the others round to nearest
	always_comb begin
		edge_round = (i_q != last_idx) && (sq_rem > {1'b0, sq_root});
		edge_len   = ACC_W'(sq_root) + ACC_W'(edge_round);
	end

	always_comb begin
		sq_start = state_q == S_ADD;
		sq_din   = SQ_W'(sqx_q) + SQ_W'(sqy_q);
	end

	// memory port steering
	always_comb begin
		wen        = '0;
		waddr      = IDX_W'(slot);
		tour_wdata = city_id;
		tour_ra    = i_q;
		tour_rb    = nxt_idx;
		city_ra    = IDX_W'(tour_qa);
		city_rb    = IDX_W'(tour_qb);
		unique case (state_q)
			S_IDLE: begin
				wen.city = take && slot_ok && (in_mode == tpss_pkg::MODE_CITY);
				wen.tour = take && slot_ok && (in_mode == tpss_pkg::MODE_TOUR);
			end
			S_PRD: begin
				tour_ra = IDX_W'(slot_q);
				tour_rb = IDX_W'(sec_q);
			end
			S_SW1: begin
				wen.tour   = 1'b1;
				waddr      = IDX_W'(slot_q);
				tour_wdata = t2_q;
			end
			S_SW2: begin
				wen.tour   = 1'b1;
				waddr      = IDX_W'(sec_q);
				tour_wdata = t1_q;
			end
			S_RV1: begin
				wen.tour   = 1'b1;
				waddr      = IDX_W'(slot_q);
				tour_wdata = t1_q;
			end
			S_RV2: begin
				wen.tour   = 1'b1;
				waddr      = IDX_W'(sec_q);
				tour_wdata = t2_q;
			end
			default: begin
			end
		endcase
	end

	// pair table write: clearing pass, then marking
	always_comb begin
		pair_we = 1'b0;
		pair_wa = clr_q;
		pair_wd = 1'b0;
		if (state_q == S_CLR) begin
			pair_we = 1'b1;
		end else if (state_q == S_PDEC && inr_q && !pair_rd_q) begin
			pair_we = 1'b1;
			pair_wa = pair_idx;
			pair_wd = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_we) begin
			pair_mem[pair_wa] <= pair_wd;
		end
		pair_rd_q <= pair_mem[pair_idx];
	end

	// register port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= tpss_pkg::CITY_COUNT_RST;
		end else if (psel && penable && pwrite && pready
		             && (paddr[2] == tpss_pkg::REG_CITY_COUNT)) begin
			city_count_q <= pwdata[CCNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tpss_pkg::REG_CITY_COUNT) ? 32'(city_count_q) : '0;

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			acc_out_q <= 1'b0;
			swp_out_q <= 1'b0;
			old_q     <= '0;
			new_q     <= '0;
			used_q    <= '0;
			exh_q     <= 1'b0;
			slot_q    <= '0;
			sec_q     <= '0;
			inr_q     <= 1'b0;
			phase_q   <= 1'b0;
			i_q       <= '0;
			acc_q     <= '0;
			before_q  <= '0;
			after_q   <= '0;
			t1_q      <= '0;
			t2_q      <= '0;
			va_q      <= 1'b0;
			vb_q      <= 1'b0;
			dx_q      <= '0;
			dy_q      <= '0;
			sqx_q     <= '0;
			sqy_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					if (clr_q == PAIR_W'(PAIR_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (take) begin
						if (in_mode == tpss_pkg::MODE_SWAP) begin
							slot_q  <= slot;
							sec_q   <= second_slot;
							inr_q   <= in_range;
							phase_q <= 1'b0;
							i_q     <= '0;
							acc_q   <= '0;
							state_q <= (n == '0) ? S_LEND : S_TRD;
						end else begin
							// loads and unused codes answer at once
							done_q    <= 1'b1;
							acc_out_q <= 1'b0;
							swp_out_q <= 1'b0;
							old_q     <= '0;
							new_q     <= '0;
							used_q    <= cnt_q;
							exh_q     <= exh_now;
						end
					end
				end
				S_TRD: state_q <= S_CRD;
				S_CRD: begin
					va_q    <= 32'(tour_qa) < MAX_CITIES;
					vb_q    <= 32'(tour_qb) < MAX_CITIES;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					dx_q    <= (xa_v > xb_v) ? xa_v - xb_v : xb_v - xa_v;
					dy_q    <= (ya_v > yb_v) ? ya_v - yb_v : yb_v - ya_v;
					state_q <= S_MUL;
				end
				S_MUL: begin
					sqx_q   <= SQ1_W'(dx_q) * SQ1_W'(dx_q);
					sqy_q   <= SQ1_W'(dy_q) * SQ1_W'(dy_q);
					state_q <= S_ADD;
				end
				S_ADD: state_q <= S_SQ;
				S_SQ: begin
					if (sq_done) begin
						acc_q <= acc_q + edge_len;
						if (i_q == last_idx) begin
							state_q <= S_LEND;
						end else begin
							i_q     <= nxt_idx;
							state_q <= S_TRD;
						end
					end
				end
				S_LEND: begin
					if (!phase_q) begin
						before_q <= acc_q;
						state_q  <= S_PRD;
					end else if (acc_q > before_q) begin
						after_q   <= before_q;
						acc_out_q <= 1'b0;
						state_q   <= S_RV1;
					end else begin
						after_q   <= acc_q;
						acc_out_q <= 1'b1;
						state_q   <= S_FIN;
					end
				end
				S_PRD: state_q <= S_PDEC;
				S_PDEC: begin
					t1_q <= tour_qa;
					t2_q <= tour_qb;
					if (inr_q && !pair_rd_q) begin
						cnt_q     <= cnt_q + 1'b1;
						swp_out_q <= 1'b1;
						state_q   <= S_SW1;
					end else begin
						// pair used or out of range: nothing moves
						after_q   <= before_q;
						acc_out_q <= 1'b1;
						swp_out_q <= 1'b0;
						state_q   <= S_FIN;
					end
				end
				S_SW1: state_q <= S_SW2;
				S_SW2: begin
					phase_q <= 1'b1;
					i_q     <= '0;
					acc_q   <= '0;
					state_q <= S_TRD;
				end
				S_RV1: state_q <= S_RV2;
				S_RV2: state_q <= S_FIN;
				S_FIN: begin
					done_q  <= 1'b1;
					old_q   <= sat_before;
					new_q   <= sat_after;
					used_q  <= cnt_q;
					exh_q   <= exh_now;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign accepted   = acc_out_q;
	assign swapped    = swp_out_q;
	assign old_length = old_q;
	assign new_length = new_q;
	assign pairs_used = used_q;
	assign exhausted  = exh_q;

	tpss_store #(
		.MAX_CITIES (MAX_CITIES),
		.COORD_BITS (COORD_BITS)
	) u_store (
		.clk        (clk),
		.wen        (wen),
		.waddr      (waddr),
		.tour_wdata (tour_wdata),
		.x_wdata    (COORD_BITS'(coord_x)),
		.y_wdata    (COORD_BITS'(coord_y)),
		.tour_ra    (tour_ra),
		.tour_rb    (tour_rb),
		.tour_qa    (tour_qa),
		.tour_qb    (tour_qb),
		.city_ra    (city_ra),
		.city_rb    (city_rb),
		.xa         (xa),
		.ya         (ya),
		.xb         (xb),
		.yb         (yb)
	);

	tpss_sqrt #(
		.RW (RW)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.din    (sq_din),
		.done   (sq_done),
		.root   (sq_root),
		.rem    (sq_rem)
	);

	// a result never shows while a trial or the clearing pass runs
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the pair count only ever steps by one
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> cnt_q == $past(cnt_q) + 1'b1)
		else $error("pair count jumped");

	// no swap tried means the length is unchanged
	a_noswap_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && !swapped |-> new_length == old_length)
		else $error("length changed without a swap");

	// a kept swap never lengthens the tour
	a_keep_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && swapped && accepted |-> new_length <= old_length)
		else $error("kept swap grew the tour");

endmodule

// ===== src/tpss_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpss_sqrt: iterative integer square root
// one root bit per cycle, gives root and remainder of the radicand
// ----------------------------------------------------------------------------
module tpss_sqrt #(
	parameter int RW = tpss_pkg::COORD_BITS_DEF + 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] din,
	output logic            done,
	output logic [RW-1:0]   root,
	output logic [RW:0]     rem
);

	localparam int CW = $clog2(RW);

	logic [2*RW-1:0] rad_q;
	logic [RW-1:0]   root_q;
	logic [RW:0]     rem_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;
	logic            done_q;

	logic [RW+2:0] rem_x;
	logic [RW+2:0] trial;
	logic          fit;

	always_comb begin
		rem_x = {rem_q, rad_q[2*RW-1 -: 2]};
		trial = (RW+3)'({root_q, 2'b01});
		fit   = rem_x >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(RW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= din;
			root_q <= '0;
			rem_q  <= '0;
		end else if (run_q) begin
			rad_q <= rad_q << 2;
			if (fit) begin
				rem_q  <= (RW+1)'(rem_x - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= (RW+1)'(rem_x);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
	assign rem  = rem_q;

endmodule

// ===== src/tpss_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpss_store: tour and city coordinate memories
// one write port, two registered read ports each
// ----------------------------------------------------------------------------
module tpss_store #(
	parameter int MAX_CITIES = tpss_pkg::MAX_CITIES_DEF,
	parameter int COORD_BITS = tpss_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  tpss_pkg::tpss_wen_t                 wen,
	input  logic [$clog2(MAX_CITIES)-1:0]       waddr,
	input  logic [tpss_pkg::CID_W-1:0]          tour_wdata,
	input  logic [COORD_BITS-1:0]               x_wdata,
	input  logic [COORD_BITS-1:0]               y_wdata,
	input  logic [$clog2(MAX_CITIES)-1:0]       tour_ra,
	input  logic [$clog2(MAX_CITIES)-1:0]       tour_rb,
	output logic [tpss_pkg::CID_W-1:0]          tour_qa,
	output logic [tpss_pkg::CID_W-1:0]          tour_qb,
	input  logic [$clog2(MAX_CITIES)-1:0]       city_ra,
	input  logic [$clog2(MAX_CITIES)-1:0]       city_rb,
	output logic [COORD_BITS-1:0]               xa,
	output logic [COORD_BITS-1:0]               ya,
	output logic [COORD_BITS-1:0]               xb,
	output logic [COORD_BITS-1:0]               yb
);

	logic [tpss_pkg::CID_W-1:0] tour_mem [MAX_CITIES];
	logic [COORD_BITS-1:0]      x_mem    [MAX_CITIES];
	logic [COORD_BITS-1:0]      y_mem    [MAX_CITIES];

	always_ff @(posedge clk) begin
		if (wen.tour) begin
			tour_mem[waddr] <= tour_wdata;
		end
		tour_qa <= tour_mem[tour_ra];
		tour_qb <= tour_mem[tour_rb];
	end

	always_ff @(posedge clk) begin
		if (wen.city) begin
			x_mem[waddr] <= x_wdata;
			y_mem[waddr] <= y_wdata;
		end
		xa <= x_mem[city_ra];
		ya <= y_mem[city_ra];
		xb <= x_mem[city_rb];
		yb <= y_mem[city_rb];
	end

endmodule
